>>> rtl/first_fit_heap_allocator_unit_assert.svh
// Assertion macros for the first-fit heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define FFHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ffha_pkg.sv
// Package: types, constants and helpers of the first-fit heap allocator.
package ffha_pkg;

  localparam int HEAP_LIMIT_BYTES = 65536;
  localparam int PAGE_BYTES       = 4096;
  localparam int HEADER_BYTES     = 16;
  localparam int MIN_SPLIT_BYTES  = HEADER_BYTES + 8;
  localparam int HDR_DEPTH        = 8192;
  localparam int GIDX_W           = 13;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_SIZE   = 2'd2,
    OP_EXTEND = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_LIMIT       = 2'd1,
    ST_DOUBLE_FREE = 2'd2,
    ST_BAD_PTR     = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] request_bytes;
    logic [31:0] pointer;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [16:0] block_bytes;
    logic [31:0] heap_top;
    logic [1:0]  status;
  } out_item_t;

  // One block header, kept per 8-byte granule.
  typedef struct packed {
    logic        present;
    logic        used;
    logic [16:0] size;
    logic [15:0] prev;
  } hdr_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_A_READ,
    S_A_CHECK,
    S_A_SPLIT,
    S_A_FINAL,
    S_G_START,
    S_G_MOD,
    S_L_CHECK,
    S_F_NEXT,
    S_F_PREV,
    S_F_PMERGE,
    S_F_PCLR,
    S_RL_READ,
    S_RL_WRITE,
    S_DONE
  } state_t;

  function automatic logic [GIDX_W-1:0] gidx(input logic [16:0] off);
    return off[GIDX_W+2:3];
  endfunction

endpackage

>>> rtl/first_fit_heap_allocator_unit.sv
// Top level: first-fit heap allocator with split, coalesce and page growth.
//
// Header memory: one 8192 x 35 synchronous RAM, one header per 8-byte
// granule, one read (registered) and one write per cycle.
// After reset a clearing pass walks all 8192 entries, one per cycle, and
// leaves one free block of a page minus header at offset 0; no item is
// accepted during the clearing pass (heap_base writes are taken anyway).
// Per item: a size query reads the block header unless the pointer is null
// or out of heap; a free merges the block with its free neighbors and ends
// early when the pointer is null, unknown or already free; an extend of
// zero bytes or one refused at the limit ends early, as does an allocate
// of zero bytes. Allocate walks the headers, one memory read per block, up
// to the first fit and splits it when it is large enough; when nothing
// fits, the heap first grows by whole pages, unless refused at the limit.
// A finished result waits in an output register, and the next item is
// accepted while it waits.
`include "first_fit_heap_allocator_unit_assert.svh"

module first_fit_heap_allocator_unit import ffha_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [31:0] cfg_data
);

  // header memory
  hdr_t mem [HDR_DEPTH];
  hdr_t mem_q;
  logic [GIDX_W-1:0] rd_addr;
  logic              we;
  logic [GIDX_W-1:0] wr_addr;
  hdr_t              wr_data;

  state_t state, state_next;
  state_t rl_ret;

  // captured item
  logic [1:0]  op_q;
  logic [15:0] req_q;
  logic [31:0] ptr_q;

  // heap bookkeeping
  logic [31:0] heap_base;
  logic [16:0] top_off;
  logic [15:0] last_off;

  // working registers
  logic [16:0] cur_off;
  hdr_t        cur;
  logic [15:0] rl_off;
  logic [16:0] rl_next;
  logic [31:0] res_q;
  logic [16:0] bytes_q;
  logic [1:0]  status_q;
  logic [GIDX_W-1:0] clr_cnt;

  // derived values
  logic [16:0] need_sum, need;
  logic [16:0] grow_n;
  logic [17:0] grow_sum, grow_total;
  logic        grow_fit;
  logic [31:0] loc_d, loc_o;
  logic        loc_bad;
  logic        fit;
  logic        split;
  logic [16:0] split_off;
  logic [16:0] mem_next;

  localparam logic [17:0] PageMask = 18'(PAGE_BYTES - 1);

  // request rounded up to 8 bytes
  assign need_sum = {1'b0, req_q} + 17'd7;
  assign need     = {need_sum[16:3], 3'b000};

  // growth in whole pages, header included; never zero pages
  assign grow_n     = (op_q == OP_ALLOC) ? need : {1'b0, req_q};
  assign grow_sum   = {1'b0, grow_n} + 18'(HEADER_BYTES + PAGE_BYTES - 1);
  assign grow_total = grow_sum & ~PageMask;
  assign grow_fit   = ({1'b0, top_off} + grow_total) <= 18'(HEAP_LIMIT_BYTES);

  // payload pointer to header offset
  assign loc_d   = ptr_q - heap_base;
  assign loc_o   = loc_d - 32'(HEADER_BYTES);
  assign loc_bad = (loc_d < 32'(HEADER_BYTES)) || (loc_o >= {15'd0, top_off}) ||
                   (loc_o[2:0] != 3'd0);

  assign fit       = !mem_q.used && (mem_q.size >= need);
  assign split     = cur.size >= (need + 17'(MIN_SPLIT_BYTES));
  assign split_off = cur_off + 17'(HEADER_BYTES) + need;
  assign mem_next  = cur_off + 17'(HEADER_BYTES) + mem_q.size;

  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == '1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (op_q)
          OP_ALLOC:  state_next = (req_q == 16'd0) ? S_DONE : S_A_READ;
          OP_EXTEND: state_next = (req_q == 16'd0) ? S_DONE : S_G_START;
          default: begin
            if (ptr_q == 32'd0 || loc_bad) state_next = S_DONE;
            else state_next = S_L_CHECK;
          end
        endcase
      end
      S_A_READ:  state_next = (cur_off < top_off) ? S_A_CHECK : S_G_START;
      S_A_CHECK: state_next = fit ? S_A_SPLIT : S_A_READ;
      S_A_SPLIT: state_next = split ? S_RL_READ : S_A_FINAL;
      S_A_FINAL: state_next = S_DONE;
      S_G_START: state_next = grow_fit ? S_G_MOD : S_DONE;
      S_G_MOD:   state_next = (op_q == OP_ALLOC) ? S_A_SPLIT : S_DONE;
      S_L_CHECK: begin
        if (!mem_q.present || op_q == OP_SIZE || !mem_q.used) state_next = S_DONE;
        else if (mem_next < top_off) state_next = S_F_NEXT;
        else state_next = S_F_PREV;
      end
      S_F_NEXT:   state_next = mem_q.used ? S_F_PREV : S_RL_READ;
      S_F_PREV:   state_next = (cur_off != 17'd0) ? S_F_PMERGE : S_DONE;
      S_F_PMERGE: state_next = mem_q.used ? S_DONE : S_F_PCLR;
      S_F_PCLR:   state_next = S_RL_READ;
      S_RL_READ:  state_next = (rl_next < top_off) ? S_RL_WRITE : rl_ret;
      S_RL_WRITE: state_next = rl_ret;
      S_DONE: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory control and handshake
  always_comb begin
    in_ready = (state == S_IDLE);
    rd_addr  = gidx(cur_off);
    we       = 1'b0;
    wr_addr  = gidx(cur_off);
    wr_data  = cur;
    unique case (state)
      S_CLEAR: begin
        we      = 1'b1;
        wr_addr = clr_cnt;
        wr_data = '0;
        if (clr_cnt == '0) begin
          wr_data.present = 1'b1;
          wr_data.size    = 17'(PAGE_BYTES - HEADER_BYTES);
        end
      end
      S_DISPATCH: rd_addr = gidx(loc_o[16:0]);
      S_G_START:  rd_addr = gidx({1'b0, last_off});
      S_G_MOD: begin
        we = 1'b1;
        if (!mem_q.used) begin
          wr_addr      = gidx({1'b0, last_off});
          wr_data      = mem_q;
          wr_data.size = mem_q.size + grow_total[16:0];
        end else begin
          wr_addr = gidx(top_off);
          wr_data = '{present: 1'b1, used: 1'b0,
                      size: grow_total[16:0] - 17'(HEADER_BYTES), prev: last_off};
        end
      end
      S_A_SPLIT: begin
        if (split) begin
          we      = 1'b1;
          wr_addr = gidx(split_off);
          wr_data = '{present: 1'b1, used: 1'b0,
                      size: cur.size - need - 17'(HEADER_BYTES), prev: cur_off[15:0]};
        end
      end
      S_A_FINAL: begin
        we           = 1'b1;
        wr_data.used = 1'b1;
      end
      S_L_CHECK: rd_addr = gidx(mem_next);
      S_F_NEXT: begin
        if (!mem_q.used) begin
          we              = 1'b1;
          wr_addr         = gidx(rl_next);
          wr_data         = mem_q;
          wr_data.present = 1'b0;
        end
      end
      S_F_PREV: begin
        we      = 1'b1;
        rd_addr = gidx({1'b0, cur.prev});
      end
      S_F_PMERGE: begin
        if (!mem_q.used) begin
          we           = 1'b1;
          wr_addr      = gidx({1'b0, cur.prev});
          wr_data      = mem_q;
          wr_data.size = mem_q.size + 17'(HEADER_BYTES) + cur.size;
        end
      end
      S_F_PCLR: begin
        we              = 1'b1;
        wr_data.present = 1'b0;
      end
      S_RL_READ: rd_addr = gidx(rl_next);
      S_RL_WRITE: begin
        we           = 1'b1;
        wr_addr      = gidx(rl_next);
        wr_data      = mem_q;
        wr_data.prev = rl_off;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mem_q <= mem[rd_addr];
    if (we) mem[wr_addr] <= wr_data;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      heap_base <= 32'd0;
      top_off   <= 17'(PAGE_BYTES);
      last_off  <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) heap_base <= cfg_data;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state == S_G_MOD) begin
        top_off <= top_off + grow_total[16:0];
        if (mem_q.used) last_off <= top_off[15:0];
      end
      if (state == S_RL_READ && !(rl_next < top_off)) last_off <= rl_off;
      if (state == S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_q  <= in_data.op;
      req_q <= in_data.request_bytes;
      ptr_q <= in_data.pointer;
    end
    unique case (state)
      S_DISPATCH: begin
        res_q    <= 32'd0;
        bytes_q  <= 17'd0;
        status_q <= ((op_q == OP_FREE || op_q == OP_SIZE) && ptr_q != 32'd0 && loc_bad) ?
                    ST_BAD_PTR : ST_OK;
        cur_off  <= (op_q == OP_ALLOC) ? 17'd0 : loc_o[16:0];
      end
      S_A_CHECK: begin
        if (fit) cur <= mem_q;
        else cur_off <= mem_next;
      end
      S_G_START: begin
        if (!grow_fit) status_q <= ST_LIMIT;
      end
      S_G_MOD: begin
        if (!mem_q.used) begin
          cur     <= '{present: mem_q.present, used: mem_q.used,
                       size: mem_q.size + grow_total[16:0], prev: mem_q.prev};
          cur_off <= {1'b0, last_off};
        end else begin
          cur     <= '{present: 1'b1, used: 1'b0,
                       size: grow_total[16:0] - 17'(HEADER_BYTES), prev: last_off};
          cur_off <= top_off;
        end
      end
      S_A_SPLIT: begin
        if (split) begin
          rl_off   <= split_off[15:0];
          rl_next  <= cur_off + 17'(HEADER_BYTES) + cur.size;
          rl_ret   <= S_A_FINAL;
          cur.size <= need;
        end
      end
      S_A_FINAL: begin
        res_q   <= heap_base + 32'(cur_off) + 32'(HEADER_BYTES);
        bytes_q <= cur.size;
      end
      S_L_CHECK: begin
        if (!mem_q.present) status_q <= ST_BAD_PTR;
        else if (op_q == OP_SIZE) bytes_q <= mem_q.size;
        else if (!mem_q.used) status_q <= ST_DOUBLE_FREE;
        cur     <= '{present: mem_q.present, used: 1'b0, size: mem_q.size,
                     prev: mem_q.prev};
        rl_next <= mem_next;
      end
      S_F_NEXT: begin
        if (!mem_q.used) begin
          cur.size <= cur.size + 17'(HEADER_BYTES) + mem_q.size;
          rl_off   <= cur_off[15:0];
          rl_next  <= cur_off + 17'(HEADER_BYTES) + cur.size + 17'(HEADER_BYTES) + mem_q.size;
          rl_ret   <= S_F_PREV;
        end
      end
      S_F_PMERGE: begin
        if (!mem_q.used) begin
          rl_off  <= cur.prev;
          rl_next <= {1'b0, cur.prev} + 17'(HEADER_BYTES) + mem_q.size +
                     17'(HEADER_BYTES) + cur.size;
          rl_ret  <= S_DONE;
        end
      end
      default: ;
    endcase
    if (state == S_DONE && (!out_valid || out_ready)) begin
      out_data.result_address <= (op_q == OP_EXTEND) ? heap_base + 32'(top_off) : res_q;
      out_data.block_bytes    <= bytes_q;
      out_data.heap_top       <= heap_base + 32'(top_off);
      out_data.status         <= status_q;
    end
  end

  `FFHA_ASSERT(a_heap_in_limit, top_off <= 17'(HEAP_LIMIT_BYTES), "heap end past limit")
  `FFHA_ASSERT(a_heap_paged, top_off[11:0] == 12'd0, "heap end not page aligned")
  `FFHA_ASSERT(a_last_in_heap, {1'b0, last_off} < top_off, "last block outside heap")
  `FFHA_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state == S_DISPATCH,
                    "accepted item did not start")

endmodule
